// ----- sv/sedge_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge RGB package
// Shared types and constants of the Sobel edge core: pixel and job types,
// queue sizing and configuration register indexes.
// ----------------------------------------------------------------------------
package sedge_pkg;

   localparam int CHAN_W = 8;
   localparam int PIX_W = 3 * CHAN_W;

   localparam int FW_W = 11;
   localparam int FH_W = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QLVL_W = 3;

   localparam int GRAD_W = 11;
   localparam int SUM_W = 21;
   localparam int ROOT_STAGES = 8;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      pix_type [2:0][2:0] win;
      logic top_ok;
      logic bottom_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } job_type;

   typedef struct packed {
      logic [QLVL_W-1:0] level;
      logic empty;
   } queue_status_type;

   function automatic chan_type pix_chan(pix_type p, logic [1:0] k);
      chan_type c;
      case (k)
         2'd2: c = p[23:16];
         2'd1: c = p[15:8];
         default: c = p[7:0];
      endcase
      return c;
   endfunction

endpackage

// ----- sv/sedge_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge request channel
// Valid/ready channel that carries one input pixel or flush beat.
// ----------------------------------------------------------------------------
interface sedge_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source(output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink(input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

// ----- sv/sedge_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge response channel
// Valid/ready channel that carries one edge magnitude beat.
// ----------------------------------------------------------------------------
interface sedge_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] red_edge;
   logic [7:0] green_edge;
   logic [7:0] blue_edge;
   logic frame_last;

   modport source(output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
   modport sink(input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

// ----- sv/sobel_edge_rgb_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge RGB core
// 3x3 Sobel gradient magnitude per color channel over a raster RGB stream.
// ----------------------------------------------------------------------------
// The core accepts one pixel beat per clock, while the job queue has room,
// once the line stores are cleared: after reset it zeroes every entry of both
// line stores and holds req ready low during that pass. The result for pixel p
// leaves with the beat at raster position p + width + 1; rsp valid rises after
// that beat has passed the front-end register, the queue, the gradient, the
// square, the eight root stages and the output register, and a low rsp ready
// can stall it on the way. The sustained rate is one beat per cycle while the
// queue has room. Send width + 1 flush beats after each frame.
module sobel_edge_rgb_core #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   sedge_req_if.sink req_bus,
   sedge_rsp_if.source rsp_bus,
   input  logic csr_write,
   input  logic [sedge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sedge_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [sedge_pkg::FW_W-1:0] width_ff;
   logic [sedge_pkg::FH_W-1:0] height_ff;
   logic push;
   logic pop;
   sedge_pkg::job_type push_job;
   sedge_pkg::job_type pop_job;
   sedge_pkg::queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sedge_pkg::FRAME_WIDTH_RESET;
         height_ff <= sedge_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sedge_pkg::CSR_FRAME_WIDTH: width_ff <= csr_wdata[sedge_pkg::FW_W-1:0];
            sedge_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[sedge_pkg::FH_W-1:0];
            default: ;
         endcase
      end
   end

   sedge_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_bus.valid),
      .in_ready(req_bus.ready),
      .in_kind(req_bus.kind),
      .in_pix({req_bus.red_in, req_bus.green_in, req_bus.blue_in}),
      .frame_width(width_ff),
      .frame_height(height_ff),
      .q_status(q_status),
      .push(push),
      .push_job(push_job)
   );

   sedge_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .pop(pop),
      .pop_job(pop_job),
      .status(q_status)
   );

   sedge_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(!q_status.empty),
      .job(pop_job),
      .pop(pop),
      .out_valid(rsp_bus.valid),
      .out_ready(rsp_bus.ready),
      .out_red(rsp_bus.red_edge),
      .out_green(rsp_bus.green_edge),
      .out_blue(rsp_bus.blue_edge),
      .out_last(rsp_bus.frame_last)
   );

endmodule

// ----- sv/sedge_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge front end
// Tracks the raster position, keeps the two line stores and the 3x3 window,
// and hands one job per produced pixel to the queue with its border masks.
// ----------------------------------------------------------------------------
module sedge_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_kind,
   input  sedge_pkg::pix_type in_pix,
   input  logic [sedge_pkg::FW_W-1:0] frame_width,
   input  logic [sedge_pkg::FH_W-1:0] frame_height,
   input  sedge_pkg::queue_status_type q_status,
   output logic push,
   output sedge_pkg::job_type push_job
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3);
   localparam int WX = (CW > sedge_pkg::FW_W) ? CW : sedge_pkg::FW_W;
   localparam int HX = (RW + 1 > sedge_pkg::FH_W) ? RW + 1 : sedge_pkg::FH_W;

   logic [WX-1:0] fw_x;
   logic [HX-1:0] fh_x;
   logic [CW-1:0] w;
   logic [RW:0] h;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic wrap;
   logic [CW-1:0] c;
   logic [RW:0] r;
   logic [RW:0] cr;
   logic [CW-1:0] cc;
   logic out_ok;
   logic is_last;
   logic [CW:0] c1;
   logic [RW:0] rn;
   logic accept;
   logic [AW-1:0] addr;
   sedge_pkg::pix_type px;

   logic clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic s1_valid_ff;
   logic s1_out_ff;
   sedge_pkg::pix_type s1_px_ff;
   logic [AW-1:0] s1_addr_ff;
   logic s1_top_ff, s1_bot_ff, s1_left_ff, s1_right_ff, s1_last_ff;
   logic top_ok, bot_ok, left_ok, right_ok;

   sedge_pkg::pix_type older_mem [MAX_WIDTH];
   sedge_pkg::pix_type newer_mem [MAX_WIDTH];
   sedge_pkg::pix_type older_rd_ff, newer_rd_ff;

   sedge_pkg::pix_type [2:0][2:0] win_ff, win_in;

   always_comb begin
      fw_x = WX'(frame_width);
      fh_x = HX'(frame_height);
      if (fw_x == '0) begin
         w = CW'(1);
      end else if (fw_x > WX'(MAX_WIDTH)) begin
         w = CW'(MAX_WIDTH);
      end else begin
         w = CW'(fw_x);
      end
      if (fh_x == '0) begin
         h = (RW + 1)'(1);
      end else if (fh_x > HX'(MAX_HEIGHT)) begin
         h = (RW + 1)'(MAX_HEIGHT);
      end else begin
         h = (RW + 1)'(fh_x);
      end
   end

   always_comb begin
      wrap = col_ff >= w;
      c = wrap ? '0 : col_ff;
      r = wrap ? {1'b0, row_ff} + (RW + 1)'(1) : {1'b0, row_ff};
      if (c != '0) begin
         out_ok = r >= (RW + 1)'(1);
         cr = r - (RW + 1)'(1);
         cc = c - CW'(1);
      end else begin
         out_ok = r >= (RW + 1)'(2);
         cr = r - (RW + 1)'(2);
         cc = w - CW'(1);
      end
      out_ok = out_ok && (cr < h);
      is_last = out_ok && (cr == h - (RW + 1)'(1)) && (cc == w - CW'(1));
      top_ok = cr != '0;
      bot_ok = ((RW + 2)'(cr) + (RW + 2)'(1)) < (RW + 2)'(h);
      left_ok = cc != '0;
      right_ok = ((CW + 1)'(cc) + (CW + 1)'(1)) < (CW + 1)'(w);
      c1 = (CW + 1)'(c) + (CW + 1)'(1);
      if (c1 >= (CW + 1)'(w)) begin
         col_in = '0;
         rn = r + (RW + 1)'(1);
      end else begin
         col_in = CW'(c1);
         rn = r;
      end
      row_in = RW'(rn);
      if (is_last || ((RW + 2)'(rn) > (RW + 2)'(h) + (RW + 2)'(1))) begin
         col_in = '0;
         row_in = '0;
      end
      if (!accept) begin
         col_in = col_ff;
         row_in = row_ff;
      end
      addr = c[AW-1:0];
      px = (in_kind == sedge_pkg::KIND_FLUSH) ? '0 : in_pix;
   end

   assign in_ready = !clear_ff &&
      ((q_status.level + sedge_pkg::QLVL_W'(s1_valid_ff)) <
       sedge_pkg::QLVL_W'(sedge_pkg::QUEUE_DEPTH));
   assign accept = in_valid && in_ready;

   always_comb begin
      clear_in = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         clear_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s1_out_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         clear_ff <= clear_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= accept;
         s1_out_ff <= accept && out_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff <= px;
         s1_addr_ff <= addr;
         s1_top_ff <= top_ok;
         s1_bot_ff <= bot_ok;
         s1_left_ff <= left_ok;
         s1_right_ff <= right_ok;
         s1_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         older_mem[clr_addr_ff] <= '0;
         newer_mem[clr_addr_ff] <= '0;
      end else if (s1_valid_ff) begin
         older_mem[s1_addr_ff] <= newer_rd_ff;
         newer_mem[s1_addr_ff] <= s1_px_ff;
      end
      if (accept) begin
         if (s1_valid_ff && (s1_addr_ff == addr)) begin
            older_rd_ff <= newer_rd_ff;
            newer_rd_ff <= s1_px_ff;
         end else begin
            older_rd_ff <= older_mem[addr];
            newer_rd_ff <= newer_mem[addr];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = older_rd_ff;
      win_in[1][2] = newer_rd_ff;
      win_in[2][2] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   assign push = s1_valid_ff && s1_out_ff;

   always_comb begin
      push_job.win = win_in;
      push_job.top_ok = s1_top_ff;
      push_job.bottom_ok = s1_bot_ff;
      push_job.left_ok = s1_left_ff;
      push_job.right_ok = s1_right_ff;
      push_job.last = s1_last_ff;
   end

endmodule

// ----- sv/sedge_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge job queue
// Short first-in first-out buffer of window jobs between front and back end.
// ----------------------------------------------------------------------------
module sedge_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sedge_pkg::job_type push_job,
   input  logic pop,
   output sedge_pkg::job_type pop_job,
   output sedge_pkg::queue_status_type status
);

   sedge_pkg::job_type q_mem [sedge_pkg::QUEUE_DEPTH];
   logic [sedge_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sedge_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sedge_pkg::QLVL_W-1:0] level_ff, level_in;
   logic do_pop;

   assign do_pop = pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + sedge_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + sedge_pkg::QPTR_W'(1) : rd_ptr_ff;
      level_in = level_ff + sedge_pkg::QLVL_W'(push) - sedge_pkg::QLVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job = q_mem[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = level_ff == '0;

endmodule

// ----- sv/sedge_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge back end
// Forms Gx and Gy per channel, squares them, takes the rounded square root
// one bit per stage and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module sedge_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  sedge_pkg::job_type job,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output logic [7:0] out_red,
   output logic [7:0] out_green,
   output logic [7:0] out_blue,
   output logic out_last
);

   localparam int NS = sedge_pkg::ROOT_STAGES;

   logic adv;

   logic g_valid_ff;
   logic g_last_ff;
   logic signed [sedge_pkg::GRAD_W-1:0] gx_ff [3];
   logic signed [sedge_pkg::GRAD_W-1:0] gy_ff [3];
   logic signed [sedge_pkg::GRAD_W-1:0] gx_in [3];
   logic signed [sedge_pkg::GRAD_W-1:0] gy_in [3];

   logic rt_valid_ff [NS+1];
   logic rt_last_ff [NS+1];
   logic [sedge_pkg::SUM_W-1:0] rt_s_ff [NS+1][3];
   logic [7:0] rt_acc_ff [NS+1][3];
   logic [7:0] rt_acc_in [NS+1][3];
   logic [sedge_pkg::SUM_W-1:0] sq_in [3];

   logic out_valid_ff;
   logic out_last_ff;
   logic [7:0] out_edge_ff [3];

   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && job_valid;

   always_comb begin
      logic [7:0] v [3][3];
      logic rok [3];
      logic cok [3];
      logic [9:0] pos_x, neg_x, pos_y, neg_y;
      rok[0] = job.top_ok;
      rok[1] = 1'b1;
      rok[2] = job.bottom_ok;
      cok[0] = job.left_ok;
      cok[1] = 1'b1;
      cok[2] = job.right_ok;
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               v[i][j] = (rok[i] && cok[j]) ?
                  sedge_pkg::pix_chan(job.win[i][j], 2'(2 - k)) : 8'd0;
            end
         end
         pos_x = 10'(v[0][2]) + {1'b0, v[1][2], 1'b0} + 10'(v[2][2]);
         neg_x = 10'(v[0][0]) + {1'b0, v[1][0], 1'b0} + 10'(v[2][0]);
         pos_y = 10'(v[2][0]) + {1'b0, v[2][1], 1'b0} + 10'(v[2][2]);
         neg_y = 10'(v[0][0]) + {1'b0, v[0][1], 1'b0} + 10'(v[0][2]);
         gx_in[k] = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
         gy_in[k] = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
      end
   end

   always_comb begin
      logic signed [2*sedge_pkg::GRAD_W-1:0] sqx;
      logic signed [2*sedge_pkg::GRAD_W-1:0] sqy;
      for (int k = 0; k < 3; k++) begin
         sqx = gx_ff[k] * gx_ff[k];
         sqy = gy_ff[k] * gy_ff[k];
         sq_in[k] = sqx[sedge_pkg::SUM_W-1:0] + sqy[sedge_pkg::SUM_W-1:0];
      end
   end

   always_comb begin
      logic [7:0] t;
      logic [15:0] prod;
      for (int st = 0; st <= NS; st++) begin
         for (int k = 0; k < 3; k++) begin
            rt_acc_in[st][k] = rt_acc_ff[st][k];
         end
      end
      for (int st = 0; st < NS; st++) begin
         for (int k = 0; k < 3; k++) begin
            t = rt_acc_ff[st][k] | (8'h80 >> st);
            prod = 16'(t) * 16'(t - 8'd1);
            if (sedge_pkg::SUM_W'(prod) < rt_s_ff[st][k]) begin
               rt_acc_in[st][k] = t;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         for (int st = 0; st <= NS; st++) begin
            rt_valid_ff[st] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= job_valid;
         rt_valid_ff[0] <= g_valid_ff;
         for (int st = 0; st < NS; st++) begin
            rt_valid_ff[st+1] <= rt_valid_ff[st];
         end
         out_valid_ff <= rt_valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_last_ff <= job.last;
         for (int k = 0; k < 3; k++) begin
            gx_ff[k] <= gx_in[k];
            gy_ff[k] <= gy_in[k];
            rt_s_ff[0][k] <= sq_in[k];
            rt_acc_ff[0][k] <= 8'd0;
            out_edge_ff[k] <= rt_acc_ff[NS][k];
         end
         rt_last_ff[0] <= g_last_ff;
         for (int st = 0; st < NS; st++) begin
            rt_last_ff[st+1] <= rt_last_ff[st];
            for (int k = 0; k < 3; k++) begin
               rt_s_ff[st+1][k] <= rt_s_ff[st][k];
               rt_acc_ff[st+1][k] <= rt_acc_in[st][k];
            end
         end
         out_last_ff <= rt_last_ff[NS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_red = out_edge_ff[0];
   assign out_green = out_edge_ff[1];
   assign out_blue = out_edge_ff[2];
   assign out_last = out_last_ff;

endmodule
